// ===== sv/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VWT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition never holds
`define VWT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/vwt_pkg.sv =====
// ----------------------------------------------------------------------------
// vwt_pkg
// Shared types and constants of the vertex weld table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vwt_pkg;

  localparam int TABLE_DEPTH  = 256;
  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);
  localparam int COORD_W      = 32;
  localparam int INDEX_W      = 8;
  localparam int STATUS_W     = 2;
  localparam int RADIUS_W     = 32;
  localparam int MAG_W        = 16;
  localparam int SQ_W         = 2 * MAG_W;
  localparam int SUM_W        = SQ_W + 2;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 32'd43;
  localparam logic ACT_CLEAR  = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] w;
  } vertex_t;

  typedef struct packed {
    logic             v;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_MATCHED  = 2'd0,
    ST_APPENDED = 2'd1,
    ST_FULL     = 2'd2,
    ST_CLEARED  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== sv/vertex_weld_table.sv =====
// ----------------------------------------------------------------------------
// vertex_weld_table
// Vertex welding table: returns the index of the first stored vertex within
// the squared radius, or appends the new vertex.
// ----------------------------------------------------------------------------
// On an add the stored vertices sit in a ring of cells that rotates once
// around, one entry per cycle past a three-stage distance compare, and the
// pipeline then drains before the result strobe. A clear shows its result
// in the cycle after it is taken. busy is low in the cycle that shows a
// result, so the next start is taken there. done_o is high for one cycle
// only and the receiver cannot stall it; results must be captured when they
// appear.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vertex_weld_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         action_i,
  input  logic signed [31:0]           coord_x_i,
  input  logic signed [31:0]           coord_y_i,
  input  logic signed [31:0]           coord_z_i,
  input  logic signed [31:0]           coord_w_i,
  output logic                         done_o,
  output logic [vwt_pkg::INDEX_W-1:0]  vertex_index_o,
  output logic [vwt_pkg::STATUS_W-1:0] status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vwt_pkg::RADIUS_W-1:0] cfg_wdata_i
);
  import vwt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_WAIT = 3'b100
  } state_e;

  state_e           st_q, st_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] found_idx_q, found_idx_d;
  logic             done_q, done_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          status_q, status_d;
  logic [RADIUS_W-1:0] radius_q;
  vertex_t          query_q;

  vertex_t ring_in  [TABLE_DEPTH];
  vertex_t ring_out [TABLE_DEPTH];
  logic    shift;
  logic    accept;
  tag_t    scan_tag, res_tag;
  logic    res_match;
  logic    hit;
  logic [IDX_W-1:0] hit_idx;

  assign accept      = start && !busy;
  assign busy        = (st_q != S_IDLE);
  assign cfg_ready_o = !busy;
  assign shift       = (st_q == S_SCAN);

  // rotating ring, head is cell 0; new vertex enters at the append slot
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_ring
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign ring_in[i] = (CNT_W'(step_q) == count_q) ? query_q : ring_out[0];
    end else begin : g_body
      assign ring_in[i] = ring_out[i+1];
    end
    vwt_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .vtx_i   (ring_in[i]),
      .vtx_o   (ring_out[i])
    );
  end

  always_comb begin
    scan_tag.v    = shift && (CNT_W'(step_q) < count_q);
    scan_tag.last = shift && (step_q == IDX_W'(TABLE_DEPTH - 1));
    scan_tag.idx  = step_q;
  end

  vwt_dist u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (scan_tag),
    .entry_i  (ring_out[0]),
    .query_i  (query_q),
    .radius_i (radius_q),
    .tag_o    (res_tag),
    .match_o  (res_match)
  );

  assign hit     = found_q || res_match;
  assign hit_idx = found_q ? found_idx_q : res_tag.idx;

  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    count_d     = count_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    done_d      = 1'b0;
    idx_d       = idx_q;
    status_d    = status_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (action_i == ACT_CLEAR) begin
            count_d  = '0;
            done_d   = 1'b1;
            idx_d    = '0;
            status_d = ST_CLEARED;
          end else begin
            st_d    = S_SCAN;
            step_d  = '0;
            found_d = 1'b0;
          end
        end
      end
      S_SCAN: begin
        step_d = step_q + IDX_W'(1);
        if (res_match && !found_q) begin
          found_d     = 1'b1;
          found_idx_d = res_tag.idx;
        end
        if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
          st_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (res_match && !found_q) begin
          found_d     = 1'b1;
          found_idx_d = res_tag.idx;
        end
        if (res_tag.last) begin
          st_d   = S_IDLE;
          done_d = 1'b1;
          if (hit) begin
            idx_d    = hit_idx;
            status_d = ST_MATCHED;
          end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
            idx_d    = '0;
            status_d = ST_FULL;
          end else begin
            idx_d    = count_q[IDX_W-1:0];
            status_d = ST_APPENDED;
            count_d  = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      step_q   <= '0;
      count_q  <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      radius_q <= RADIUS_RESET;
    end else begin
      st_q    <= st_d;
      step_q  <= step_d;
      count_q <= count_d;
      found_q <= found_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        radius_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    found_idx_q <= found_idx_d;
    idx_q       <= idx_d;
    status_q    <= status_d;
    if (accept) begin
      query_q.x <= coord_x_i;
      query_q.y <= coord_y_i;
      query_q.z <= coord_z_i;
      query_q.w <= coord_w_i;
    end
  end

  assign done_o         = done_q;
  assign vertex_index_o = INDEX_W'(idx_q);
  assign status_o       = status_q;

  `VWT_ASSERT_IMPLY(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(TABLE_DEPTH), "count beyond depth")
  `VWT_ASSERT_IMPLY(a_append_count, clk_i, rst_ni, done_q && status_q == ST_APPENDED, count_q == CNT_W'(idx_q) + CNT_W'(1), "append count mismatch")
  `VWT_ASSERT_IMPLY(a_clear_count, clk_i, rst_ni, done_q && status_q == ST_CLEARED, count_q == '0, "clear left entries")
  `VWT_ASSERT_IMPLY(a_last_in_wait, clk_i, rst_ni, res_tag.last, st_q == S_WAIT, "scan end outside wait")
  `VWT_ASSERT_NEVER(a_done_in_scan, clk_i, rst_ni, st_q == S_SCAN && done_q, "result during scan")

endmodule

`default_nettype wire

// ===== sv/vwt_cell.sv =====
// ----------------------------------------------------------------------------
// vwt_cell
// One stored vertex of the rotating table ring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vwt_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  vwt_pkg::vertex_t vtx_i,
  output vwt_pkg::vertex_t vtx_o
);
  import vwt_pkg::*;

  vertex_t vtx_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      vtx_q <= vtx_i;
    end
  end

  assign vtx_o = vtx_q;

endmodule

`default_nettype wire

// ===== sv/vwt_dist.sv =====
// ----------------------------------------------------------------------------
// vwt_dist
// Three-stage squared distance compare of a stored vertex against the query.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vwt_dist (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vwt_pkg::tag_t                tag_i,
  input  vwt_pkg::vertex_t             entry_i,
  input  vwt_pkg::vertex_t             query_i,
  input  logic [vwt_pkg::RADIUS_W-1:0] radius_i,
  output vwt_pkg::tag_t                tag_o,
  output logic                         match_o
);
  import vwt_pkg::*;

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W:0]        ax, ay, az;
  logic                    near;

  tag_t             s1_tag_q, s2_tag_q, s3_tag_q;
  logic             s1_ok_q, s2_ok_q, s3_match_q;
  logic [MAG_W-1:0] mx_q, my_q, mz_q;
  logic [SQ_W-1:0]  sx_q, sy_q, sz_q;
  logic [SUM_W-1:0] sum;

  always_comb begin
    dx   = {entry_i.x[COORD_W-1], entry_i.x} - {query_i.x[COORD_W-1], query_i.x};
    dy   = {entry_i.y[COORD_W-1], entry_i.y} - {query_i.y[COORD_W-1], query_i.y};
    dz   = {entry_i.z[COORD_W-1], entry_i.z} - {query_i.z[COORD_W-1], query_i.z};
    ax   = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
    ay   = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
    az   = dz[COORD_W] ? (COORD_W+1)'(-dz) : dz;
    near = (ax[COORD_W:MAG_W] == '0) && (ay[COORD_W:MAG_W] == '0) &&
           (az[COORD_W:MAG_W] == '0);
  end

  assign sum = SUM_W'(sx_q) + SUM_W'(sy_q) + SUM_W'(sz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q   <= '0;
      s2_tag_q   <= '0;
      s3_tag_q   <= '0;
      s1_ok_q    <= 1'b0;
      s2_ok_q    <= 1'b0;
      s3_match_q <= 1'b0;
    end else begin
      s1_tag_q   <= tag_i;
      s2_tag_q   <= s1_tag_q;
      s3_tag_q   <= s2_tag_q;
      s1_ok_q    <= near;
      s2_ok_q    <= s1_ok_q;
      s3_match_q <= s2_ok_q && (sum < SUM_W'(radius_i));
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q <= ax[MAG_W-1:0];
    my_q <= ay[MAG_W-1:0];
    mz_q <= az[MAG_W-1:0];
    sx_q <= mx_q * mx_q;
    sy_q <= my_q * my_q;
    sz_q <= mz_q * mz_q;
  end

  assign tag_o   = s3_tag_q;
  assign match_o = s3_match_q && s3_tag_q.v;

endmodule

`default_nettype wire

// ===== tb/vertex_weld_table_test.sv =====
// ----------------------------------------------------------------------------
// vertex_weld_table_test
// Self-checking testbench of the vertex weld table. A short directed run hits
// exact and near duplicates, the 1.0 axis limit, sums of squares that pass
// 32 bits, coordinates at both ends of the range, clears and a zero radius.
// Random phases then sweep the weld radius, mix near duplicates of stored
// vertices with clustered and random ones, and fill the table to see drops.
// Every result is checked against an own model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [vwt_pkg::INDEX_W-1:0] index;
  vwt_pkg::status_e            status;
} weld_answer_t;

class weld_scoreboard;
  logic [31:0]  pos_x [vwt_pkg::TABLE_DEPTH];
  logic [31:0]  pos_y [vwt_pkg::TABLE_DEPTH];
  logic [31:0]  pos_z [vwt_pkg::TABLE_DEPTH];
  int unsigned  count;
  int unsigned  peak;
  logic [31:0]  radius_sq;
  weld_answer_t answers [$];
  int unsigned  errors;
  int unsigned  tally [4];

  function new();
    count     = 0;
    peak      = 0;
    radius_sq = vwt_pkg::RADIUS_RESET;
    errors    = 0;
    foreach (tally[i]) tally[i] = 0;
  endfunction

  function void set_radius(logic [31:0] value);
    radius_sq = value;
  endfunction

  function int unsigned pending();
    return answers.size();
  endfunction

  // exact magnitude of stored minus incoming, at 33 bits
  static function logic [33:0] axis_mag(logic [31:0] held, logic [31:0] fresh);
    logic [32:0] d;
    logic [32:0] m;
    d = {held[31], held} - {fresh[31], fresh};
    m = d[32] ? (~d + 1'b1) : d;
    return {1'b0, m};
  endfunction

  function bit in_reach(int unsigned e, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    logic [33:0] mx;
    logic [33:0] my;
    logic [33:0] mz;
    logic [33:0] sum;
    mx = axis_mag(pos_x[e], x);
    my = axis_mag(pos_y[e], y);
    mz = axis_mag(pos_z[e], z);
    if (mx >= 34'd65536 || my >= 34'd65536 || mz >= 34'd65536) return 1'b0;
    sum = mx * mx + my * my + mz * mz;
    return sum < {2'b00, radius_sq};
  endfunction

  function void note_input(logic act, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    weld_answer_t a;
    bit           hit;
    hit = 1'b0;
    if (act == vwt_pkg::ACT_CLEAR) begin
      count    = 0;
      a.index  = '0;
      a.status = vwt_pkg::ST_CLEARED;
    end else begin
      for (int unsigned e = 0; e < count && !hit; e++) begin
        if (in_reach(e, x, y, z)) begin
          a.index  = e[vwt_pkg::INDEX_W-1:0];
          a.status = vwt_pkg::ST_MATCHED;
          hit      = 1'b1;
        end
      end
      if (!hit) begin
        if (count == vwt_pkg::TABLE_DEPTH) begin
          a.index  = '0;
          a.status = vwt_pkg::ST_FULL;
        end else begin
          pos_x[count] = x;
          pos_y[count] = y;
          pos_z[count] = z;
          a.index      = count[vwt_pkg::INDEX_W-1:0];
          a.status     = vwt_pkg::ST_APPENDED;
          count++;
          if (count > peak) peak = count;
        end
      end
    end
    answers.push_back(a);
  endfunction

  task report_mismatch(string what);
    if (errors < 40) $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(logic [vwt_pkg::INDEX_W-1:0] idx, logic [vwt_pkg::STATUS_W-1:0] st);
    weld_answer_t a;
    if (answers.size() == 0) begin
      report_mismatch($sformatf("result index %0d status %0d with nothing pending", idx, st));
    end else begin
      a = answers.pop_front();
      if (st !== a.status)
        report_mismatch($sformatf("status %0d, expected %s", st, a.status.name()));
      if (idx !== a.index)
        report_mismatch($sformatf("index %0d, expected %0d (%s)", idx, a.index,
                                  a.status.name()));
      tally[a.status]++;
    end
  endtask
endclass

module vertex_weld_table_test;

  localparam logic        ACT_ADD        = ~vwt_pkg::ACT_CLEAR;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 200;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic        action_i       = 1'b0;
  logic [31:0] coord_x_i      = '0;
  logic [31:0] coord_y_i      = '0;
  logic [31:0] coord_z_i      = '0;
  logic [31:0] coord_w_i      = '0;
  logic        done_o;
  logic [vwt_pkg::INDEX_W-1:0]  vertex_index_o;
  logic [vwt_pkg::STATUS_W-1:0] status_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_wdata_i    = '0;

  weld_scoreboard sb;
  int unsigned    idle_cycles = 0;
  int unsigned    items_sent  = 0;
  int unsigned    radius_writes = 0;
  bit             quiet       = 1'b0;
  logic [31:0]    cluster_x;
  logic [31:0]    cluster_y;
  logic [31:0]    cluster_z;
  logic [31:0]    radius_plan [8];

  vertex_weld_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .coord_w_i      (coord_w_i),
    .done_o         (done_o),
    .vertex_index_o (vertex_index_o),
    .status_o       (status_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(vertex_index_o, status_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  function automatic logic [31:0] nudge(logic [31:0] base);
    logic [31:0] d;
    case ($urandom_range(0, 9))
      0, 1, 2: d = 0;
      3, 4, 5: d = $urandom_range(0, 6);
      6:       d = $urandom_range(0, 65535);
      7:       d = $urandom_range(65535, 65536);
      8:       d = $urandom_range(0, 40000);
      default: d = $urandom_range(0, 300);
    endcase
    return $urandom_range(0, 1) ? base + d : base - d;
  endfunction

  task automatic send_item(logic act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    action_i  <= act;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    coord_w_i <= w;
    do @(posedge clk_i); while (busy);
    sb.note_input(act, x, y, z);
    items_sent++;
  endtask

  // stop sending and wait for every pending result
  task automatic wait_table_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_weld_radius(logic [31:0] value);
    wait_table_idle();
    cfg_valid_i <= 1'b1;
    cfg_wdata_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_radius(value);
    radius_writes++;
  endtask

  task automatic send_random(int unsigned clear_pct, int unsigned near_pct,
                             int unsigned cluster_pct);
    int unsigned r;
    int unsigned pick;
    r = $urandom_range(0, 99);
    if (r < clear_pct) begin
      send_item(vwt_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    end else if (r < clear_pct + near_pct && sb.count != 0) begin
      pick = $urandom_range(0, sb.count - 1);
      send_item(ACT_ADD, nudge(sb.pos_x[pick]), nudge(sb.pos_y[pick]),
                nudge(sb.pos_z[pick]), $urandom);
    end else if (r < clear_pct + near_pct + cluster_pct) begin
      send_item(ACT_ADD, cluster_x + $urandom_range(0, 64) - 32,
                cluster_y + $urandom_range(0, 64) - 32,
                cluster_z + $urandom_range(0, 64) - 32, $urandom);
    end else begin
      send_item(ACT_ADD, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset radius: exact and near duplicates, range extremes
    send_item(vwt_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_item(ACT_ADD, 32'd6, 32'd0, 32'd0, 32'd5);
    send_item(ACT_ADD, -32'sd3, -32'sd3, -32'sd3, 32'd0);
    send_item(ACT_ADD, 32'd4, 32'd4, 32'd3, 32'd0);
    send_item(ACT_ADD, 32'd4, 32'd4, 32'd4, 32'd0);
    send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(ACT_ADD, 32'h7FFF_FFFC, 32'h7FFF_FFFD, 32'h7FFF_FFFF, 32'h1234_5678);
    send_item(ACT_ADD, 32'h8000_0001, 32'h8000_0000, 32'h8000_0002, 32'h0);
    send_item(vwt_pkg::ACT_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);

    // widest radius: the 1.0 axis limit and sums above 32 bits
    write_weld_radius(32'hFFFF_FFFF);
    send_item(vwt_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0);
    send_item(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd65535, 32'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd65536, 32'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd0, -32'sd65536, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd0, 32'd0, -32'sd65535, 32'd0);
    send_item(ACT_ADD, 32'd37837, 32'd37837, 32'd37837, 32'd0);
    send_item(ACT_ADD, 32'd37838, 32'd37838, 32'd37838, 32'd0);

    // zero radius never welds
    write_weld_radius(32'd0);
    send_item(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(ACT_ADD, 32'd0, 32'd0, 32'd0, 32'd0);

    radius_plan[0] = 32'hFFFF_FFFF;
    radius_plan[1] = vwt_pkg::RADIUS_RESET;
    radius_plan[2] = 32'd0;
    radius_plan[3] = 32'd1;
    radius_plan[4] = 32'h0010_0000;
    radius_plan[5] = $urandom;
    radius_plan[6] = 32'h8000_0000;
    radius_plan[7] = $urandom_range(0, 65535);

    for (int ph = 0; ph < 8; ph++) begin
      write_weld_radius(radius_plan[ph]);
      cluster_x = $urandom;
      cluster_y = $urandom;
      cluster_z = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) wait_table_idle();
        send_random(3, 45, 15);
      end
    end

    // fill the table past its depth, then keep welding against a full table
    write_weld_radius(32'h0001_0000);
    quiet = 1'b0;
    send_item(vwt_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < 420; i++) send_random(0, 20, 0);

    wait_table_idle();
    repeat (8) @(posedge clk_i);

    $display("run: %0d items, %0d radius writes, table filled up to %0d entries",
             items_sent, radius_writes, sb.peak);
    $display("run: checked %0d matched, %0d appended, %0d dropped full, %0d cleared",
             sb.tally[vwt_pkg::ST_MATCHED], sb.tally[vwt_pkg::ST_APPENDED],
             sb.tally[vwt_pkg::ST_FULL], sb.tally[vwt_pkg::ST_CLEARED]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/vwt_pkg.sv
sv/vwt_cell.sv
sv/vwt_dist.sv
sv/vertex_weld_table.sv
tb/vertex_weld_table_test.sv
